// ===== rtl/core/dll_pkg.sv =====
// shared types, constants and helpers for the linked list manager
package dll_pkg;

  localparam int unsigned NODES = 64;
  localparam int unsigned IdxW  = $clog2(NODES + 1);
  localparam int unsigned AddrW = $clog2(NODES);
  localparam int unsigned NodeW = 6;
  localparam int unsigned OpW   = 3;
  localparam int unsigned CntW  = 7;

  localparam logic [IdxW-1:0] NoneIdx  = IdxW'(NODES);
  localparam logic [CntW-1:0] CountMax = '1;

  localparam logic StatusDone  = 1'b0;
  localparam logic StatusEmpty = 1'b1;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ACT_NOP,
    ACT_PUSH_F,
    ACT_PUSH_B,
    ACT_UNLINK
  } act_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [NodeW-1:0] node_index;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0] node_out;
    logic            status;
    logic [CntW-1:0] item_count;
  } rsp_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [IdxW-1:0]  wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  function automatic logic is_node(logic [IdxW-1:0] v);
    return v < NoneIdx;
  endfunction

  function automatic logic [IdxW-1:0] norm_idx(logic [IdxW-1:0] v);
    return is_node(v) ? v : NoneIdx;
  endfunction

endpackage

// ===== rtl/core/dll_link_mem.sv =====
// one link memory: one write port, one read port with registered data
module dll_link_mem (
  input  logic                      clk_i,
  input  dll_pkg::mem_req_t         req_i,
  output logic [dll_pkg::IdxW-1:0]  rdata_o
);
  import dll_pkg::*;

  logic [IdxW-1:0] mem_q [NODES];
  logic [IdxW-1:0] rdata_q;

  // read returns the old entry when read and write hit the same address
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dll_seq.sv =====
// request sequencer: head, tail and count registers, link memory accesses
module dll_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  dll_pkg::req_t            req_i,
  input  logic                     out_room_i,
  output logic                     rsp_valid_o,
  output dll_pkg::rsp_t            rsp_o,
  output dll_pkg::mem_req_t        nxt_req_o,
  output dll_pkg::mem_req_t        prv_req_o,
  input  logic [dll_pkg::IdxW-1:0] nxt_rd_i,
  input  logic [dll_pkg::IdxW-1:0] prv_rd_i
);
  import dll_pkg::*;

  state_e          state_q, state_d;
  act_e            act_q, act_d;
  logic [IdxW-1:0] tgt_q, tgt_d;
  logic [IdxW-1:0] node_q, node_d;
  logic            status_q, status_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [IdxW-1:0] h, t, e, p, x, n_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      act_q   <= ACT_NOP;
      head_q  <= NoneIdx;
      tail_q  <= NoneIdx;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q    <= tgt_d;
    node_q   <= node_d;
    status_q <= status_d;
  end

  always_comb begin
    h     = norm_idx(head_q);
    t     = norm_idx(tail_q);
    e     = (req_i.op == OP_POP_FRONT) ? h : t;
    p     = norm_idx(prv_rd_i);
    x     = norm_idx(nxt_rd_i);
    n_ext = IdxW'(req_i.node_index);

    state_d     = state_q;
    act_d       = act_q;
    tgt_d       = tgt_q;
    node_d      = node_q;
    status_d    = status_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    nxt_req_o   = '0;
    prv_req_o   = '0;
    in_ready_o  = 1'b0;
    rsp_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d  = ST_EXEC;
          act_d    = ACT_NOP;
          tgt_d    = n_ext;
          node_d   = n_ext;
          status_d = StatusDone;
          case (req_i.op)
            OP_PUSH_FRONT: begin
              if (is_node(n_ext)) begin
                act_d           = ACT_PUSH_F;
                nxt_req_o.we    = 1'b1;
                nxt_req_o.waddr = n_ext[AddrW-1:0];
                nxt_req_o.wdata = h;
                prv_req_o.we    = 1'b1;
                prv_req_o.waddr = n_ext[AddrW-1:0];
                prv_req_o.wdata = NoneIdx;
              end
            end
            OP_PUSH_BACK: begin
              if (is_node(n_ext)) begin
                act_d           = ACT_PUSH_B;
                prv_req_o.we    = 1'b1;
                prv_req_o.waddr = n_ext[AddrW-1:0];
                prv_req_o.wdata = t;
                nxt_req_o.we    = 1'b1;
                nxt_req_o.waddr = n_ext[AddrW-1:0];
                nxt_req_o.wdata = NoneIdx;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (is_node(e)) begin
                act_d = ACT_UNLINK;
                tgt_d = e;
                node_d = e;
              end else begin
                node_d   = NoneIdx;
                status_d = StatusEmpty;
              end
            end
            OP_REMOVE: begin
              if (is_node(n_ext)) begin
                act_d = ACT_UNLINK;
              end
            end
            default: begin
              act_d = ACT_NOP;
            end
          endcase
          // unlink: fetch both links and clear them in the same cycle
          if (act_d == ACT_UNLINK) begin
            nxt_req_o.re    = 1'b1;
            nxt_req_o.raddr = tgt_d[AddrW-1:0];
            nxt_req_o.we    = 1'b1;
            nxt_req_o.waddr = tgt_d[AddrW-1:0];
            nxt_req_o.wdata = NoneIdx;
            prv_req_o.re    = 1'b1;
            prv_req_o.raddr = tgt_d[AddrW-1:0];
            prv_req_o.we    = 1'b1;
            prv_req_o.waddr = tgt_d[AddrW-1:0];
            prv_req_o.wdata = NoneIdx;
          end
        end
      end
      ST_EXEC: begin
        if (out_room_i) begin
          rsp_valid_o = 1'b1;
          state_d     = ST_IDLE;
          case (act_q)
            ACT_PUSH_F: begin
              if (is_node(h)) begin
                if (h != tgt_q) begin
                  prv_req_o.we    = 1'b1;
                  prv_req_o.waddr = h[AddrW-1:0];
                  prv_req_o.wdata = tgt_q;
                end
              end else begin
                tail_d = tgt_q;
              end
              head_d = tgt_q;
              if (cnt_q < CountMax) cnt_d = cnt_q + CntW'(1);
            end
            ACT_PUSH_B: begin
              if (is_node(t)) begin
                if (t != tgt_q) begin
                  nxt_req_o.we    = 1'b1;
                  nxt_req_o.waddr = t[AddrW-1:0];
                  nxt_req_o.wdata = tgt_q;
                end
              end else begin
                head_d = tgt_q;
              end
              tail_d = tgt_q;
              if (cnt_q < CountMax) cnt_d = cnt_q + CntW'(1);
            end
            ACT_UNLINK: begin
              // a neighbor equal to the node itself keeps its cleared link
              if (is_node(p)) begin
                if (p != tgt_q) begin
                  nxt_req_o.we    = 1'b1;
                  nxt_req_o.waddr = p[AddrW-1:0];
                  nxt_req_o.wdata = x;
                end
              end else begin
                head_d = x;
              end
              if (is_node(x)) begin
                if (x != tgt_q) begin
                  prv_req_o.we    = 1'b1;
                  prv_req_o.waddr = x[AddrW-1:0];
                  prv_req_o.wdata = p;
                end
              end else begin
                tail_d = p;
              end
              if (cnt_q != '0) cnt_d = cnt_q - CntW'(1);
            end
            default: begin
              cnt_d = cnt_q;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    rsp_o.node_out   = node_q;
    rsp_o.status     = status_q;
    rsp_o.item_count = cnt_d;
  end

endmodule

// ===== rtl/core/doubly_linked_list_manager.sv =====
// Doubly linked list manager over a pool of 64 node indices (64 means none).
// Each request passes through the idle and exec states: in the transfer cycle a pop or
// remove reads the node's next and prev links from the two link memories and
// clears them, and a push writes the new node's own links; in the exec state
// the neighbors' links are written back through the single write port of each
// memory and head, tail and count are updated. No new request is taken until
// the exec state of the last one ends; the exec state waits only while the
// output register still holds an untaken result. Link memories are not
// cleared after reset: under correct use every link is written before read.
module doubly_linked_list_manager (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dll_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dll_pkg::rsp_t  out_data_o
);
  import dll_pkg::*;

  // requests from the sequencer to the next and prev link memories
  mem_req_t        nxt_req, prv_req;
  logic [IdxW-1:0] nxt_rd, prv_rd;

  // finished result handed to the output register
  logic rsp_valid;
  rsp_t rsp;
  logic out_room;

  // output register parts the two sides
  logic out_valid_q;
  rsp_t out_data_q;

  dll_link_mem u_next_mem (
    .clk_i   (clk_i),
    .req_i   (nxt_req),
    .rdata_o (nxt_rd)
  );

  dll_link_mem u_prev_mem (
    .clk_i   (clk_i),
    .req_i   (prv_req),
    .rdata_o (prv_rd)
  );

  dll_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_i       (in_data_i),
    .out_room_i  (out_room),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .nxt_req_o   (nxt_req),
    .prv_req_o   (prv_req),
    .nxt_rd_i    (nxt_rd),
    .prv_rd_i    (prv_rd)
  );

  // room when empty or when the held result leaves this cycle
  assign out_room = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a transfer in leaves the block busy for the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in progress");

  // a result is never finished in a cycle that also takes a request
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !in_ready_o)
    else $error("result finished while taking a request");

  // a result is only written when the output register has room
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> out_room)
    else $error("result overwrote an untaken one");

  // an empty report always carries the none index
  a_empty_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StatusEmpty) |-> out_data_o.node_out == NoneIdx)
    else $error("empty status without none index");

endmodule

// ===== dv/doubly_linked_list_manager_test.sv =====
// testbench for the linked list manager: directed and random requests checked against a list shadow
`timescale 1ns / 1ps

module doubly_linked_list_manager_test;
  import dll_pkg::*;

  // run limits
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 20;

  // shadow of the list: mirrors head, tail, count and both link memories
  class list_tracker;
    logic [IdxW-1:0] head;
    logic [IdxW-1:0] tail;
    logic [CntW-1:0] total;
    logic [IdxW-1:0] next_of [NODES];
    logic [IdxW-1:0] prev_of [NODES];
    bit              linked  [NODES];
    bit              written [NODES];
    rsp_t            pending_replies [$];
    int              errors;
    int              replies_seen;
    int              empty_pops;
    int              peak_total;

    function new();
      head = NoneIdx;
      tail = NoneIdx;
      total = '0;
      foreach (next_of[i]) begin
        next_of[i] = '0;
        prev_of[i] = '0;
        linked[i]  = 1'b0;
        written[i] = 1'b0;
      end
      errors = 0;
      replies_seen = 0;
      empty_pops = 0;
      peak_total = 0;
    endfunction

    // anything at or above the pool size stands for no node
    function logic [IdxW-1:0] link_or_none(logic [IdxW-1:0] v);
      return (v < NoneIdx) ? v : NoneIdx;
    endfunction

    // take node n out of the list, joining its neighbors
    function void cut(logic [IdxW-1:0] n);
      logic [IdxW-1:0] p;
      logic [IdxW-1:0] x;
      p = link_or_none(prev_of[n[AddrW-1:0]]);
      x = link_or_none(next_of[n[AddrW-1:0]]);
      if (p != NoneIdx) next_of[p[AddrW-1:0]] = x;
      else head = x;
      if (x != NoneIdx) prev_of[x[AddrW-1:0]] = p;
      else tail = p;
      prev_of[n[AddrW-1:0]] = NoneIdx;
      next_of[n[AddrW-1:0]] = NoneIdx;
      linked[n[AddrW-1:0]] = 1'b0;
      if (total != '0) total--;
    endfunction

    // update the shadow for one accepted request and queue its reply
    function void note_request(req_t r);
      rsp_t             want;
      logic [IdxW-1:0]  n;
      logic [AddrW-1:0] k;
      logic [IdxW-1:0]  h;
      logic [IdxW-1:0]  t;
      logic [IdxW-1:0]  last;
      n = IdxW'(r.node_index);
      k = r.node_index;
      want.node_out = n;
      want.status = StatusDone;
      case (r.op)
        OP_PUSH_FRONT: begin
          h = link_or_none(head);
          next_of[k] = h;
          if (h != NoneIdx) prev_of[h[AddrW-1:0]] = n;
          else tail = n;
          prev_of[k] = NoneIdx;
          head = n;
          linked[k] = 1'b1;
          written[k] = 1'b1;
          if (total != CountMax) total++;
        end
        OP_PUSH_BACK: begin
          t = link_or_none(tail);
          prev_of[k] = t;
          if (t != NoneIdx) next_of[t[AddrW-1:0]] = n;
          else head = n;
          next_of[k] = NoneIdx;
          tail = n;
          linked[k] = 1'b1;
          written[k] = 1'b1;
          if (total != CountMax) total++;
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          last = link_or_none(r.op == OP_POP_FRONT ? head : tail);
          if (last == NoneIdx) begin
            want.node_out = NoneIdx;
            want.status = StatusEmpty;
            empty_pops++;
          end else begin
            cut(last);
            want.node_out = last;
          end
        end
        OP_REMOVE: cut(n);
        default: ;  // unused op codes leave the list alone
      endcase
      want.item_count = total;
      if (int'(total) > peak_total) peak_total = int'(total);
      pending_replies.push_back(want);
    endfunction

    function void compare(string field, int want, logic [IdxW-1:0] got);
      if ((^got === 1'bx) || (int'(got) != want)) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // check one reply transfer against the oldest queued reply
    function void check_reply(rsp_t got);
      rsp_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, got node %0d status %0d count %0d",
                 $time, got.node_out, got.status, got.item_count);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      replies_seen++;
      compare("node_out", int'(want.node_out), got.node_out);
      compare("status", int'(want.status), IdxW'(got.status));
      compare("item_count", int'(want.item_count), IdxW'(got.item_count));
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  list_tracker sb;
  bit          quiet = 1'b0;   // no idling on either side while set
  int          sent = 0;
  int          cycles = 0;
  // push percentage per random segment: fill to the top, drain, then wander
  int          fill_plan [7] = '{85, 85, 85, 15, 70, 30, 15};

  doubly_linked_list_manager u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_data_i   (req_data),
    .out_valid_o (rsp_valid),
    .out_ready_i (rsp_ready),
    .out_data_o  (rsp_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // random node that is (or is not) in the list, scanning from a random start
  function automatic logic [NodeW-1:0] pick_node(bit want_linked);
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] k;
    int               i;
    start = AddrW'($urandom_range(0, NODES - 1));
    for (i = 0; i < NODES; i++) begin
      k = start + AddrW'(i);
      if (sb.linked[k] == want_linked) return NodeW'(k);
    end
    return NodeW'(start);
  endfunction

  // one request transfer; valid only drops when a gap follows
  task automatic send_request(logic [OpW-1:0] op, logic [NodeW-1:0] node);
    int   gap;
    req_t r;
    gap = pick_gap();
    r.op = op;
    r.node_index = node;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_data <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    // transfer happened at this edge
    sb.note_request(r);
    sent++;
  endtask

  // proper use: push only free nodes, remove only linked ones, now and then an unused op code
  task automatic send_well_formed(int push_pct);
    if ($urandom_range(0, 99) < 4) begin
      send_request(OpW'($urandom_range(5, 7)), NodeW'($urandom));
    end else if ($urandom_range(0, 99) < push_pct && sb.total < CntW'(NODES)) begin
      send_request($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_node(1'b0));
    end else if (sb.total != '0 && $urandom_range(0, 2) == 0) begin
      send_request(OP_REMOVE, pick_node(1'b1));
    end else begin
      send_request($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, NodeW'($urandom));
    end
  endtask

  // reply side: random stalls with ready high stretches in between
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // every reply transfer is checked at the edge it happens
  always @(posedge clk) begin
    if (rst_n && rsp_valid && rsp_ready) sb.check_reply(rsp_data);
  end

  // watchdog
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int s;
    logic [NodeW-1:0] n;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pops, single node, all positions of remove, unused ops
    send_request(OP_POP_FRONT, 6'd0);
    send_request(OP_POP_BACK, 6'd63);
    send_request(OP_PUSH_FRONT, 6'd0);
    send_request(OP_POP_BACK, 6'd0);
    send_request(OP_REMOVE, 6'd0);        // remove from an empty list, count stays at zero
    send_request(OP_PUSH_BACK, 6'd63);
    send_request(OP_PUSH_FRONT, 6'd0);
    send_request(OP_PUSH_BACK, 6'd42);
    send_request(OP_PUSH_FRONT, 6'd21);
    send_request(OP_REMOVE, 6'd63);       // middle node
    send_request(OP_REMOVE, 6'd21);       // head
    send_request(OP_REMOVE, 6'd42);       // tail
    send_request(3'd5, 6'd63);
    send_request(3'd6, 6'd0);
    send_request(3'd7, 6'd42);
    send_request(OP_PUSH_BACK, 6'd21);
    send_request(OP_POP_FRONT, 6'd63);
    send_request(OP_POP_BACK, 6'd0);
    send_request(OP_POP_FRONT, 6'd0);
    send_request(OP_REMOVE, 6'd21);
    send_request(OP_PUSH_FRONT, 6'd63);
    send_request(OP_POP_FRONT, 6'd21);

    // random well-formed traffic, segments fill, then drain, then wander between the two
    for (s = 0; s < 7; s++) begin
      quiet = ($urandom_range(0, 3) == 0);
      repeat (40) send_well_formed(fill_plan[s]);
    end
    quiet = 1'b0;

    // misuse at the end: pushes of linked nodes drive the count into saturation
    repeat (135) begin
      send_request($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, NodeW'($urandom));
    end
    repeat (20) begin
      n = NodeW'($urandom);
      case ($urandom_range(0, 2))
        0: send_request($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, n);
        1: send_request(sb.written[n] ? OP_REMOVE : OP_PUSH_BACK, n);
        default: send_request(OP_PUSH_FRONT, n);
      endcase
    end
    req_valid <= 1'b0;

    // let the last replies drain
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d requests sent, %0d replies checked, %0d of them pops on an empty list",
             sent, sb.replies_seen, sb.empty_pops);
    $display("list count peaked at %0d, %0d mismatches", sb.peak_total, sb.errors);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
